>>> design/assert_macros.svh
// Assertion helpers included by nge_seq.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// The condition must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

>>> design/nge_pkg.sv
package nge_pkg;

	localparam int MAX_LEN = 64;
	localparam int DEPTH   = 64;
	localparam int IDX_W   = 6;
	localparam int CNT_W   = 7;
	localparam int VAL_W   = 32;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic                    last;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0] element_index;
		logic [IDX_W-1:0] next_index;
		logic             has_greater;
		logic             overflow;
		logic             last_result;
	} result_t;

	typedef struct packed {
		logic [IDX_W-1:0]        index;
		logic signed [VAL_W-1:0] value;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic    valid;
		result_t res;
	} emit_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_PUSH,
		ST_WAIT,
		ST_FLUSH,
		ST_OVF
	} state_t;

endpackage

>>> design/nge_stack_mem.sv
module nge_stack_mem (
	input  logic              clk,
	input  nge_pkg::mem_req_t req,
	output nge_pkg::entry_t   rd_data
);
	import nge_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rd_data <= mem[req.raddr];
	end

endmodule

>>> design/nge_seq.sv
`include "assert_macros.svh"

module nge_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  nge_pkg::item_t    item,
	output nge_pkg::emit_t    emit,
	input  logic              emit_ready,
	output nge_pkg::mem_req_t mem_req,
	input  nge_pkg::entry_t   rd_data
);
	import nge_pkg::*;

	state_t                  state_q, state_d;
	logic [CNT_W-1:0]        cnt_q, cnt_d;
	logic [CNT_W-1:0]        pos_q, pos_d;
	logic                    ovf_q, ovf_d;
	logic                    pend_q, pend_d;
	logic [IDX_W-1:0]        pend_idx_q, pend_idx_d;
	logic signed [VAL_W-1:0] val_q;
	logic                    last_q;
	logic                    capture;
	logic                    greater;
	logic [CNT_W-1:0]        top_addr;

	// The single comparator: current value against the entry on top of the stack.
	assign greater = $signed(val_q) > $signed(rd_data.value);

	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		pos_d         = pos_q;
		ovf_d         = ovf_q;
		pend_d        = pend_q;
		pend_idx_d    = pend_idx_q;
		capture       = 1'b0;
		item_ready    = 1'b0;
		emit          = '0;
		mem_req.we    = 1'b0;
		mem_req.waddr = cnt_q[IDX_W-1:0];
		mem_req.wdata = '{index: pos_q[IDX_W-1:0], value: val_q};
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					capture = 1'b1;
					if (pos_q >= CNT_W'(MAX_LEN)) begin
						ovf_d = 1'b1;
						if (!item.last || cnt_q == '0) begin
							state_d = ST_OVF;
						end else begin
							state_d = ST_FLUSH;
						end
					end else begin
						ovf_d   = 1'b0;
						state_d = (cnt_q == '0) ? ST_PUSH : ST_CMP;
					end
				end
			end
			ST_CMP: begin
				// A popped answer is held until the next compare shows whether it
				// is the final answer of the transaction.
				emit.valid             = pend_q;
				emit.res.element_index = pend_idx_q;
				emit.res.next_index    = pos_q[IDX_W-1:0];
				emit.res.has_greater   = 1'b1;
				if (cnt_q != '0 && greater) begin
					if (!pend_q || emit_ready) begin
						pend_d     = 1'b1;
						pend_idx_d = rd_data.index;
						cnt_d      = cnt_q - CNT_W'(1);
					end
				end else begin
					emit.res.last_result = !last_q;
					if (!pend_q || emit_ready) begin
						pend_d  = 1'b0;
						state_d = ST_PUSH;
					end
				end
			end
			ST_PUSH: begin
				mem_req.we = 1'b1;
				cnt_d      = cnt_q + CNT_W'(1);
				pos_d      = pos_q + CNT_W'(1);
				state_d    = last_q ? ST_WAIT : ST_IDLE;
			end
			ST_WAIT: begin
				// Lets the freshly pushed entry come out of the memory read port.
				state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				emit.valid             = 1'b1;
				emit.res.element_index = rd_data.index;
				emit.res.overflow      = ovf_q;
				emit.res.last_result   = (cnt_q == CNT_W'(1));
				if (emit_ready) begin
					cnt_d = cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						pos_d   = '0;
						state_d = ST_IDLE;
					end
				end
			end
			ST_OVF: begin
				emit.valid           = 1'b1;
				emit.res.overflow    = 1'b1;
				emit.res.last_result = 1'b1;
				if (emit_ready) begin
					if (last_q) begin
						cnt_d = '0;
						pos_d = '0;
					end
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Always address the entry that will be on top in the next cycle; during a push the read returns the old contents.
	assign top_addr       = cnt_d - CNT_W'(1);
	assign mem_req.raddr  = top_addr[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			pos_q      <= '0;
			ovf_q      <= 1'b0;
			pend_q     <= 1'b0;
			pend_idx_q <= '0;
		end else begin
			state_q    <= state_d;
			cnt_q      <= cnt_d;
			pos_q      <= pos_d;
			ovf_q      <= ovf_d;
			pend_q     <= pend_d;
			pend_idx_q <= pend_idx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			val_q  <= item.value;
			last_q <= item.last;
		end
	end

	`ASSERT_AT(a_cnt_bound, clk, arst_n, cnt_q <= CNT_W'(DEPTH), "stack count beyond depth")
	`ASSERT_AT(a_pos_bound, clk, arst_n, pos_q <= CNT_W'(MAX_LEN), "position beyond limit")
	`ASSERT_NEVER(a_read_empty, clk, arst_n,
		(state_q == ST_CMP && cnt_q == '0 && !pend_q) || (state_q == ST_FLUSH && cnt_q == '0),
		"top read on empty stack")
	`ASSERT_AT(a_pop_order, clk, arst_n,
		(emit.valid && emit.res.has_greater) |->
		(emit.res.element_index < emit.res.next_index), "popped index not older")
	`ASSERT_AT(a_end_idle, clk, arst_n,
		(emit.valid && emit_ready && emit.res.last_result) |=>
		(state_q == ST_IDLE || state_q == ST_PUSH),
		"final result not followed by idle or push")

endmodule

>>> design/next_greater_element_stream.sv
// Streaming next-greater-element finder.
// item channel (item_valid/item_ready/item): one signed 32-bit value per
// transaction, numbered from 0 by the block; item.last closes a sequence.
// result channel (result_valid/result_ready/result): one transaction per
// answer. Each arriving value answers every older waiting element it strictly
// exceeds; on last, all elements still waiting are answered with has_greater
// low, newest first. result.last_result marks the final answer of an item.
// Items past MAX_LEN in one sequence are dropped with one overflow answer,
// or, if it is a last item with elements waiting, by overflow on the flush answers.
// One item is worked on at a time, and item_ready is high only while idle.
// Items meet stacked entries one at a time, paced by the one comparator and
// the single read port of the stack memory; a last item flushes them in turn.
// Results come from an output register, in the cycle after they are produced.
// A stalled result channel holds the sequencer on the pending answer while
// the output register keeps its transaction; nothing is lost.
// Reset clears the stack count and position; stack contents are not cleared.
module next_greater_element_stream (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  nge_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output nge_pkg::result_t result
);
	import nge_pkg::*;

	emit_t    emit;
	logic     emit_ready;
	mem_req_t mem_req;
	entry_t   rd_data;
	logic     result_valid_q;
	result_t  result_q;

	nge_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.emit       (emit),
		.emit_ready (emit_ready),
		.mem_req    (mem_req),
		.rd_data    (rd_data)
	);

	nge_stack_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	assign emit_ready = !result_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit_ready) begin
			result_valid_q <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid && emit_ready) begin
			result_q <= emit.res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
